// ----- hw/rtl/sck_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sck_pkg
// Shared types for the sparse chi-square kernel: controller commands and
// datapath status.
// ----------------------------------------------------------------------------
package sck_pkg;

  typedef struct packed {
    logic load_write;   // store the input entry at stored_count
    logic clear_pair;   // clear per-pair state
    logic enter_second; // switch to second vector
    logic rd_issue;     // read stored entry at merge pointer
    logic ptr_inc;      // advance merge pointer
    logic div_start;    // start divider with latched operands
    logic acc_add;      // add quotient, count a match
    logic out_load;     // capture result into output register
    logic latch_in;     // capture input item
  } sck_cmd_t;

  typedef struct packed {
    logic ptr_lt_count; // merge pointer below stored count
    logic rd_lt;        // stored index read < input index
    logic rd_eq;        // stored index read == input index
    logic div_busy;
    logic den_zero;
  } sck_stat_t;

endpackage
`default_nettype wire

// ----- hw/rtl/sck_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sck_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module sck_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- hw/rtl/sck_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sck_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sck_div #(
  parameter int NUM_BITS = 32,
  parameter int DEN_BITS = 17
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [NUM_BITS-1:0] num,
  input  wire logic [DEN_BITS-1:0] den,
  output logic                     busy,
  output logic      [NUM_BITS-1:0] quo
);
  localparam int CW = $clog2(NUM_BITS + 1);
  logic [NUM_BITS-1:0] q;
  logic [DEN_BITS-1:0] d;
  logic [DEN_BITS:0]   rem;
  logic [CW-1:0]       cnt;
  logic [DEN_BITS:0]   trial;
  logic [DEN_BITS+1:0] diff;

  always_comb begin
    trial = {rem[DEN_BITS-1:0], q[NUM_BITS-1]};
    diff  = {1'b0, trial} - {2'b00, d};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(NUM_BITS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= num;
      d   <= den;
      rem <= '0;
    end else if (busy) begin
      if (!diff[DEN_BITS+1]) begin
        rem <= diff[DEN_BITS:0];
        q   <= {q[NUM_BITS-2:0], 1'b1};
      end else begin
        rem <= trial;
        q   <= {q[NUM_BITS-2:0], 1'b0};
      end
    end
  end

  assign quo = q;
endmodule
`default_nettype wire

// ----- hw/rtl/sck_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sck_datapath
// Stored vector, merge pointer, term divider, accumulator and result register.
// ----------------------------------------------------------------------------
module sck_datapath #(
  parameter int MAX_ENTRIES = 1024,
  parameter int INDEX_BITS  = 20,
  parameter int VALUE_BITS  = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire sck_pkg::sck_cmd_t      cmd,
  output sck_pkg::sck_stat_t          stat,
  input  wire logic                   in_present,
  input  wire logic [INDEX_BITS-1:0]  in_index,
  input  wire logic [VALUE_BITS-1:0]  in_value,
  output logic      [27:0]            kernel_value,
  output logic      [10:0]            match_count,
  output logic                        capacity_exceeded
);
  import sck_pkg::*;

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int PW = 2 * VALUE_BITS;
  localparam int DW = VALUE_BITS + 1;
  localparam int ACCW = 26;

  logic [CW-1:0]         count;
  logic [CW-1:0]         ptr;
  logic [ACCW-1:0]       acc;
  logic [10:0]           match_cnt;
  logic                  overflow;
  logic [INDEX_BITS-1:0] idx_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [INDEX_BITS-1:0] rd_idx;
  logic [VALUE_BITS-1:0] rd_val;
  logic [PW-1:0]         prod;
  logic [DW-1:0]         den;
  logic                  div_busy;
  logic [PW-1:0]         quo;
  logic [AW-1:0]         waddr;
  logic [AW-1:0]         raddr;
  logic                  we;

  assign waddr = count[AW-1:0];
  assign raddr = ptr[AW-1:0];
  assign we    = cmd.load_write && (count < CW'(MAX_ENTRIES));

  sck_ram #(.WIDTH(INDEX_BITS), .DEPTH(MAX_ENTRIES)) u_idx_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(in_index),
    .raddr(raddr), .rdata(rd_idx));
  sck_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ENTRIES)) u_val_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(in_value),
    .raddr(raddr), .rdata(rd_val));

  // product registered before the divider
  always_ff @(posedge clk) begin
    prod <= PW'(rd_val) * PW'(val_q);
    den  <= DW'(rd_val) + DW'(val_q);
  end

  sck_div #(.NUM_BITS(PW), .DEN_BITS(DW)) u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .num(prod), .den(den),
    .busy(div_busy), .quo(quo));

  always_comb begin
    stat.ptr_lt_count = ptr < count;
    stat.rd_lt        = rd_idx < idx_q;
    stat.rd_eq        = rd_idx == idx_q;
    stat.div_busy     = div_busy;
    stat.den_zero     = den == '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      idx_q <= in_index;
      val_q <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_pair) begin
      count     <= '0;
      ptr       <= '0;
      acc       <= '0;
      match_cnt <= '0;
      overflow  <= 1'b0;
    end else begin
      if (cmd.load_write && in_present) begin
        if (count < CW'(MAX_ENTRIES)) count <= count + 1'b1;
        else overflow <= 1'b1;
      end
      if (cmd.enter_second) ptr <= '0;
      else if (cmd.ptr_inc) ptr <= ptr + 1'b1;
      if (cmd.acc_add) begin
        match_cnt <= match_cnt + 1'b1;
        if (!stat.den_zero) acc <= acc + ACCW'(quo);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      kernel_value      <= 28'(32'h0002_0000 - {4'b0, acc, 2'b00});
      match_count       <= match_cnt;
      capacity_exceeded <= overflow;
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/sck_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sck_ctrl
// Sequencer: load phase, merge scan, divide, result handoff.
// ----------------------------------------------------------------------------
module sck_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_present,
  input  wire logic               in_last,
  output logic                    out_valid,
  input  wire logic               out_stall,
  input  wire sck_pkg::sck_stat_t stat,
  output sck_pkg::sck_cmd_t       cmd
);
  import sck_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_CMP   = 7'b0000100,
    S_PROD  = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_WAIT  = 7'b0100000,
    S_ADD   = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   second, second_next;
  logic   last_q, last_q_next;
  logic   out_valid_next;
  logic   accept;

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    second_next    = second;
    last_q_next    = last_q;
    out_valid_next = out_valid && out_stall;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.latch_in = 1'b1;
          if (!second) begin
            cmd.load_write = in_present;
            if (in_last) begin
              second_next      = 1'b1;
              cmd.enter_second = 1'b1;
            end
          end else if (in_present) begin
            last_q_next = in_last;
            state_next  = S_READ;
          end else if (in_last) begin
            cmd.out_load   = 1'b1;
            cmd.clear_pair = 1'b1;
            out_valid_next = 1'b1;
            second_next    = 1'b0;
          end
        end
      end
      S_READ: state_next = S_CMP; // RAM read in flight
      S_CMP: begin
        if (!stat.ptr_lt_count) state_next = S_ADD;
        else if (stat.rd_lt) begin
          cmd.ptr_inc = 1'b1;
          state_next  = S_READ;
        end else if (stat.rd_eq) state_next = S_PROD;
        else state_next = S_ADD;
      end
      S_PROD: state_next = S_DIV;
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_next    = S_WAIT;
      end
      S_WAIT: begin
        if (!stat.div_busy) begin
          cmd.acc_add = 1'b1;
          cmd.ptr_inc = 1'b1;
          state_next  = S_ADD;
        end
      end
      S_ADD: begin
        // a closing entry holds here while the previous result still waits
        if (!last_q) begin
          state_next = S_IDLE;
        end else if (!(out_valid && out_stall)) begin
          state_next     = S_IDLE;
          cmd.out_load   = 1'b1;
          cmd.clear_pair = 1'b1;
          out_valid_next = 1'b1;
          second_next    = 1'b0;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      second    <= 1'b0;
      last_q    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      second    <= second_next;
      last_q    <= last_q_next;
      out_valid <= out_valid_next;
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/sparse_chi_square_kernel.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_chi_square_kernel
// Chi-square kernel between two sparse vectors, 2 - 4*sum floor(ab/(a+b)).
// ----------------------------------------------------------------------------
// A first-vector item is stored as it is accepted, in the idle state. A
// second-vector entry passes the read and compare states for each stored entry
// the merge skips, then on a match the product, divide and wait states before the add state, else the add state.
// The result sits in an output register; input is held off while a result
// waits under stall, and a closing entry waits in its last state until the
// previous result has been taken.
module sparse_chi_square_kernel #(
  parameter int MAX_ENTRIES = 1024,
  parameter int INDEX_BITS  = 20,
  parameter int VALUE_BITS  = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  entry_present,
  input  wire logic [INDEX_BITS-1:0] row_index,
  input  wire logic [VALUE_BITS-1:0] entry_value,
  input  wire logic                  last_entry,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic signed [27:0]         kernel_value,
  output logic      [10:0]           match_count,
  output logic                       capacity_exceeded
);
  import sck_pkg::*;

  sck_cmd_t  cmd;
  sck_stat_t stat;
  logic [27:0] kv;

  sck_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_present(entry_present), .in_last(last_entry),
    .out_valid(out_valid), .out_stall(out_stall), .stat(stat), .cmd(cmd));

  sck_datapath #(.MAX_ENTRIES(MAX_ENTRIES), .INDEX_BITS(INDEX_BITS),
                 .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .in_present(entry_present), .in_index(row_index), .in_value(entry_value),
    .kernel_value(kv), .match_count(match_count),
    .capacity_exceeded(capacity_exceeded));

  assign kernel_value = signed'(kv);

  // a result is never overwritten while it waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !cmd.out_load)
    else $error("result overwritten while stalled");
  // divider never restarted while busy
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !stat.div_busy)
    else $error("divider restarted while busy");
endmodule
`default_nettype wire
